// File: rtl/core/str_pkg.sv
// Shared types and constants of the scope trace rasterizer.
package str_pkg;

    // Trace geometry
    localparam int TRACE_POINTS = 281;
    localparam int IDX_W        = 10;
    localparam int SAMPLE_W     = 8;
    localparam int X_W          = 11;
    localparam int Y_W          = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic [IDX_W-1:0] IDX_MAX       = '1;
    localparam logic [IDX_W-1:0] TP_LIMIT      = IDX_W'(TRACE_POINTS);
    localparam logic [IDX_W-1:0] TP_DOT_LIMIT  = IDX_W'(TRACE_POINTS - 1);

    // Command queue depth; two commands may enter in one cycle
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_CODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LINES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DETECT = 3'd6;

    // What a trace point turns into
    typedef enum logic [2:0] {
        DRAW_NONE,
        DRAW_LINE,
        DRAW_PEAK_LINE,
        DRAW_PEAK_DOTS,
        DRAW_DOT
    } draw_kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic                trace_start;
    } sample_word_t;

    typedef struct packed {
        logic [X_W-1:0]        pos_x;
        logic signed [Y_W-1:0] pos_y;
        logic signed [Y_W-1:0] seg_len;
        logic                  is_segment;
        logic                  run_end;
    } cmd_word_t;

    // Row mapping settings shared by the lanes
    typedef struct packed {
        logic [9:0]          center_y;
        logic [15:0]         scale_q;
        logic [SAMPLE_W-1:0] mid_level;
    } map_cfg_t;

    // Commands produced by one trace point
    typedef struct packed {
        logic [1:0] n;
        cmd_word_t  first;
        cmd_word_t  second;
    } cmd_push_t;

endpackage

// File: rtl/core/str_lane.sv
// One row-mapping lane: sample code to signed screen row.
module str_lane import str_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SAMPLE_W-1:0]   sample,
    input  map_cfg_t              map_cfg,
    output logic signed [Y_W-1:0] row
);

    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic signed [26:0] center_term;
    logic signed [26:0] t;
    logic signed [Y_W-1:0] row_next;
    logic signed [Y_W-1:0] row_reg;

    // Offset from mid level times Q4.12 scale, exact
    assign diff        = $signed({1'b0, sample}) - $signed({1'b0, map_cfg.mid_level});
    assign prod        = diff * $signed({1'b0, map_cfg.scale_q});
    // center*4096 plus half a row for round half up
    assign center_term = $signed({5'b0, map_cfg.center_y, 12'h800});
    assign t           = center_term - {prod[25], prod};
    // Floor by 4096
    assign row_next    = {t[26], t[26:12]};

    // Hold the row while the pipeline waits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

// File: rtl/core/str_merge.sv
// Merge stage: combine the two lane rows into draw commands.
module str_merge import str_pkg::*;
(
    input  draw_kind_t            kind,
    input  logic [X_W-1:0]        pos_x,
    input  logic signed [Y_W-1:0] row0,
    input  logic signed [Y_W-1:0] row1,
    output cmd_push_t             push
);

    logic signed [Y_W-1:0] line_end;

    // Segment stops one row short of the new sample
    assign line_end = (row0 > row1) ? row1 + 16'sd1 : row1 - 16'sd1;

    always_comb
    begin
        push        = '0;
        push.first.pos_x  = pos_x;
        push.second.pos_x = pos_x;
        unique case (kind)
            DRAW_LINE:
            begin
                push.n              = 2'd1;
                push.first.pos_y    = row0;
                push.first.run_end  = 1'b1;
                if (row0 != row1)
                begin
                    push.first.seg_len    = line_end - row0;
                    push.first.is_segment = 1'b1;
                end
            end
            DRAW_PEAK_LINE:
            begin
                push.n                = 2'd1;
                push.first.pos_y      = row0;
                push.first.seg_len    = row1 - row0;
                push.first.is_segment = 1'b1;
                push.first.run_end    = 1'b1;
            end
            DRAW_PEAK_DOTS:
            begin
                push.n              = 2'd2;
                push.first.pos_y    = row0;
                push.second.pos_y   = row1;
                push.second.run_end = 1'b1;
            end
            DRAW_DOT:
            begin
                push.n             = 2'd1;
                push.first.pos_y   = {8'b0, row0[7:0]};
                push.first.run_end = 1'b1;
            end
            default:
            begin
                push.n = 2'd0;
            end
        endcase
    end

endmodule

// File: rtl/core/str_fifo.sv
// Command queue: takes up to two words a cycle, hands out one while cmd_stall is low.
module str_fifo import str_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_push_t push,
    output logic      room,
    output logic      cmd_valid,
    input  logic      cmd_stall,
    output cmd_word_t cmd_word
);

    cmd_word_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_second;

    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && !cmd_stall;
    assign room          = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign cmd_word      = mem_reg[rd_ptr_reg];
    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // Advance pointers and fill level
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming words
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("command queue over full");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("push without room");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("more than two words pushed");
`endif

endmodule

// File: rtl/core/scope_trace_rasterizer.sv
// Scope trace rasterizer top level: decode, two mapping lanes, merge, command queue.
//
// Usage:
//   sample channel (sample_valid, sample_stall, sample_word): one word per
//   trace point. A word is taken at a clock edge with valid high and stall low.
//   cmd channel (cmd_valid, cmd_stall, cmd_word): zero, one or two draw
//   commands per sample word, in order; run_end marks the last of a word.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while no sample word is in flight. Unknown indexes are ignored.
// Timing:
//   A command passes the decode register, the lane row register and then the queue
//   after its sample word is taken; a full queue holds it back on the way.
//   The queue hands out one command per cycle while cmd_stall is low, so words
//   that make one command flow at one per cycle and peak-detect point words slower.
//   sample_stall rises when the four-entry command queue holds more than two
//   words; a stalled receiver then backs up into the sample side.
// Reset:
//   rst_n clears the trace history, the point index and the queue, and loads
//   the default register values; the block is ready as soon as reset is released.
module scope_trace_rasterizer import str_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_word_t         sample_word,
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output cmd_word_t            cmd_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [9:0]          center_y_reg;
    logic [9:0]          left_x_reg;
    logic [15:0]         scale_q_reg;
    logic [SAMPLE_W-1:0] mid_level_reg;
    logic [SAMPLE_W-1:0] absent_code_reg;
    logic                draw_lines_reg;
    logic                peak_detect_reg;

    // Trace history
    logic [SAMPLE_W-1:0] prev_sample_reg;
    logic                have_prev_reg;
    logic [IDX_W-1:0]    point_idx_reg, point_idx_next;

    // Decode stage
    draw_kind_t          s1_kind_reg, s1_kind_next;
    logic [X_W-1:0]      s1_x_reg, s1_x_next;
    logic [SAMPLE_W-1:0] s1_lane0_reg, s1_lane0_next;
    logic [SAMPLE_W-1:0] s1_lane1_reg, s1_lane1_next;

    // Lane stage
    draw_kind_t          s2_kind_reg;
    logic [X_W-1:0]      s2_x_reg;
    logic signed [Y_W-1:0] row0, row1;

    logic                advance;
    logic                accept;
    logic [IDX_W-1:0]    idx;
    logic                hist;
    logic                a_absent;
    logic                p_absent;
    logic [X_W-1:0]      x_base;
    map_cfg_t            map_cfg;
    cmd_push_t           merged;
    cmd_push_t           push;
    logic                room;

    assign advance      = room;
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;

    // Apply configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_y_reg    <= 10'd120;
            left_x_reg      <= 10'd20;
            scale_q_reg     <= 16'd4096;
            mid_level_reg   <= 8'd128;
            absent_code_reg <= 8'd0;
            draw_lines_reg  <= 1'b1;
            peak_detect_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_Y:    center_y_reg    <= cfg_data[9:0];
                CFG_LEFT_X:      left_x_reg      <= cfg_data[9:0];
                CFG_SCALE_Q:     scale_q_reg     <= cfg_data;
                CFG_MID_LEVEL:   mid_level_reg   <= cfg_data[7:0];
                CFG_ABSENT_CODE: absent_code_reg <= cfg_data[7:0];
                CFG_DRAW_LINES:  draw_lines_reg  <= cfg_data[0];
                CFG_PEAK_DETECT: peak_detect_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Decode the word against the trace history
    assign idx      = sample_word.trace_start ? '0 : point_idx_reg;
    assign hist     = sample_word.trace_start ? 1'b0 : have_prev_reg;
    assign a_absent = (sample_word.sample_a == absent_code_reg);
    assign p_absent = (prev_sample_reg == absent_code_reg);
    assign x_base   = {1'b0, left_x_reg} + {1'b0, idx};
    assign point_idx_next = (idx == IDX_MAX) ? idx : idx + 1'b1;

    always_comb
    begin
        s1_kind_next  = DRAW_NONE;
        s1_x_next     = x_base;
        s1_lane0_next = sample_word.sample_a;
        s1_lane1_next = sample_word.sample_b;
        priority if (draw_lines_reg && peak_detect_reg)
        begin
            s1_lane0_next = sample_word.sample_b;
            s1_lane1_next = sample_word.sample_a;
            if (idx < TP_LIMIT)
            begin
                s1_kind_next = DRAW_PEAK_LINE;
            end
        end
        else if (draw_lines_reg)
        begin
            s1_lane0_next = prev_sample_reg;
            s1_lane1_next = sample_word.sample_a;
            s1_x_next     = x_base - 1'b1;
            if (idx != '0 && idx < TP_LIMIT && hist && !a_absent && !p_absent)
            begin
                s1_kind_next = DRAW_LINE;
            end
        end
        else if (peak_detect_reg)
        begin
            if (idx < TP_LIMIT)
            begin
                s1_kind_next = DRAW_PEAK_DOTS;
            end
        end
        else
        begin
            if (idx < TP_DOT_LIMIT && !a_absent)
            begin
                s1_kind_next = DRAW_DOT;
            end
        end
        if (!accept)
        begin
            s1_kind_next = DRAW_NONE;
        end
    end

    // Hold history and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            have_prev_reg   <= 1'b0;
            point_idx_reg   <= '0;
            s1_kind_reg     <= DRAW_NONE;
            s2_kind_reg     <= DRAW_NONE;
        end
        else if (advance)
        begin
            s1_kind_reg <= s1_kind_next;
            s2_kind_reg <= s1_kind_reg;
            if (accept)
            begin
                prev_sample_reg <= sample_word.sample_a;
                have_prev_reg   <= 1'b1;
                point_idx_reg   <= point_idx_next;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg     <= s1_x_next;
            s1_lane0_reg <= s1_lane0_next;
            s1_lane1_reg <= s1_lane1_next;
            s2_x_reg     <= s1_x_reg;
        end
    end

    assign map_cfg.center_y  = center_y_reg;
    assign map_cfg.scale_q   = scale_q_reg;
    assign map_cfg.mid_level = mid_level_reg;

    // Map both samples side by side
    str_lane u_lane0 (
        .clk     (clk),
        .en      (advance),
        .sample  (s1_lane0_reg),
        .map_cfg (map_cfg),
        .row     (row0)
    );

    str_lane u_lane1 (
        .clk     (clk),
        .en      (advance),
        .sample  (s1_lane1_reg),
        .map_cfg (map_cfg),
        .row     (row1)
    );

    // Combine lane rows into commands
    str_merge u_merge (
        .kind  (s2_kind_reg),
        .pos_x (s2_x_reg),
        .row0  (row0),
        .row1  (row1),
        .push  (merged)
    );

    // Push only when the pipeline moves
    always_comb
    begin
        push = merged;
        if (!advance)
        begin
            push.n = 2'd0;
        end
    end

    str_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word)
    );

`ifndef SYNTHESIS
    a_start_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample_word.trace_start) |=> (point_idx_reg == 10'd1))
        else $error("trace start did not restart the point index");
    a_index_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sample_word.trace_start && point_idx_reg == IDX_MAX)
        |=> (point_idx_reg == IDX_MAX))
        else $error("point index wrapped");
    a_history_set: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> have_prev_reg)
        else $error("history not recorded after accepted word");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the scope trace rasterizer: draw command prediction and compare.
module tb_top
    import str_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // unmapped register index
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_SETUPS = 4;
    localparam int WORDS_PER_SETUP = 12;
    localparam int SATURATE_WORDS = 1028;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_word_t         sample_word = '0;
    logic                 cmd_valid;
    logic                 cmd_stall = 1'b0;
    cmd_word_t            cmd_word;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Register shadow
    logic [9:0]  cfg_center;
    logic [9:0]  cfg_left;
    logic [15:0] cfg_scale;
    logic [7:0]  cfg_mid;
    logic [7:0]  cfg_absent;
    logic        cfg_lines;
    logic        cfg_peak;

    // Trace history shadow
    logic [7:0]       last_sample;
    logic             have_history;
    logic [IDX_W-1:0] trace_pos;

    sample_word_t sample_feed_q[$];
    cmd_word_t    pending_cmds_q[$];

    int feed_gap = 0;
    int feed_odds = 0;
    int hold_left = 0;
    int drain_odds = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    scope_trace_rasterizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd_word     (cmd_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Row of a sample code: center - (s - mid) * scale, rounded half up
    function automatic int sample_to_row(input logic [7:0] code);
        longint diff;
        longint num;
        diff = longint'(code) - longint'(cfg_mid);
        num = longint'(cfg_center) * 4096 + 2048 - diff * longint'(cfg_scale);
        return int'(num >>> 12);
    endfunction

    task automatic push_command(input int x, input int y, input int len,
                                input logic seg, input logic last);
        cmd_word_t c;
        c.pos_x      = x[X_W-1:0];
        c.pos_y      = y[Y_W-1:0];
        c.seg_len    = len[Y_W-1:0];
        c.is_segment = seg;
        c.run_end    = last;
        pending_cmds_q.push_back(c);
    endtask

    // Expected draw commands for one accepted sample word
    task automatic predict_commands(input sample_word_t w);
        draw_kind_t kind;
        int         col;
        int         row_a;
        int         row_b;
        int         row_p;
        int         tail;
        if (w.trace_start)
        begin
            trace_pos    = '0;
            have_history = 1'b0;
        end
        col = int'(cfg_left) + int'(trace_pos);
        row_a = sample_to_row(w.sample_a);
        row_b = sample_to_row(w.sample_b);
        row_p = sample_to_row(last_sample);
        if (cfg_lines)
            kind = cfg_peak ? DRAW_PEAK_LINE : DRAW_LINE;
        else
            kind = cfg_peak ? DRAW_PEAK_DOTS : DRAW_DOT;

        case (kind)
            DRAW_PEAK_LINE:
                if (int'(trace_pos) < TRACE_POINTS)
                    push_command(col, row_b, row_a - row_b, 1'b1, 1'b1);
            DRAW_LINE:
                if (trace_pos >= 1 && int'(trace_pos) < TRACE_POINTS && have_history &&
                    w.sample_a != cfg_absent && last_sample != cfg_absent)
                begin
                    if (row_a == row_p)
                        push_command(col - 1, row_p, 0, 1'b0, 1'b1);
                    else
                    begin
                        tail = (row_p > row_a) ? row_a + 1 : row_a - 1;
                        push_command(col - 1, row_p, tail - row_p, 1'b1, 1'b1);
                    end
                end
            DRAW_PEAK_DOTS:
                if (int'(trace_pos) < TRACE_POINTS)
                begin
                    push_command(col, row_a, 0, 1'b0, 1'b0);
                    push_command(col, row_b, 0, 1'b0, 1'b1);
                end
            default:
                if (int'(trace_pos) + 1 < TRACE_POINTS && w.sample_a != cfg_absent)
                    push_command(col, row_a & 255, 0, 1'b0, 1'b1);
        endcase

        // Advance history
        last_sample  = w.sample_a;
        have_history = 1'b1;
        if (trace_pos != IDX_MAX)
            trace_pos = trace_pos + 1'b1;
    endtask

    // Sample side: feed queued words, hold while stalled, insert gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                predict_commands(sample_word);
            if (!sample_valid || !sample_stall)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap = feed_gap - 1;
                    sample_valid <= 1'b0;
                end
                else if (sample_feed_q.size() > 0)
                begin
                    sample_valid <= 1'b1;
                    sample_word  <= sample_feed_q.pop_front();
                    if (feed_odds != 0 && $urandom_range(0, feed_odds - 1) == 0)
                        feed_gap = $urandom_range(1, 11);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Command side: compare each taken word, stall in bursts
    always @(posedge clk)
    begin : cmd_check
        cmd_word_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (pending_cmds_q.size() == 0)
                begin
                    $error("unexpected command word: pos_x %0d pos_y %0d", cmd_word.pos_x,
                           cmd_word.pos_y);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_cmds_q.pop_front();
                    if (cmd_word.pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, cmd_word.pos_x);
                        mismatch_count++;
                    end
                    if (cmd_word.pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, cmd_word.pos_y);
                        mismatch_count++;
                    end
                    if (cmd_word.seg_len !== want.seg_len)
                    begin
                        $error("seg_len: expected %0d, got %0d", want.seg_len, cmd_word.seg_len);
                        mismatch_count++;
                    end
                    if (cmd_word.is_segment !== want.is_segment)
                    begin
                        $error("is_segment: expected %0d, got %0d", want.is_segment,
                               cmd_word.is_segment);
                        mismatch_count++;
                    end
                    if (cmd_word.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d", want.run_end, cmd_word.run_end);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                cmd_stall <= 1'b1;
            end
            else if (drain_odds != 0 && $urandom_range(0, drain_odds - 1) == 0)
            begin
                hold_left = $urandom_range(0, 10);
                cmd_stall <= 1'b1;
            end
            else
                cmd_stall <= 1'b0;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_CENTER_Y:    cfg_center = val[9:0];
            CFG_LEFT_X:      cfg_left   = val[9:0];
            CFG_SCALE_Q:     cfg_scale  = val;
            CFG_MID_LEVEL:   cfg_mid    = val[7:0];
            CFG_ABSENT_CODE: cfg_absent = val[7:0];
            CFG_DRAW_LINES:  cfg_lines  = val[0];
            CFG_PEAK_DETECT: cfg_peak   = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every command has come back
    task automatic settle_block();
        @(negedge clk);
        while (sample_feed_q.size() != 0 || sample_valid || pending_cmds_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic add_word(input logic [7:0] a, input logic [7:0] b, input logic start);
        sample_word_t w;
        w.sample_a    = a;
        w.sample_b    = b;
        w.trace_start = start;
        sample_feed_q.push_back(w);
    endtask

    // Register value at an extreme or random within its width
    function automatic logic [15:0] pick_value(input int width);
        logic [15:0] top;
        top = 16'((32'd1 << width) - 1);
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return top;
            default: return 16'($urandom) & top;
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 4;
            default: return 8;
        endcase
    endfunction

    task automatic apply_random_setup();
        write_reg(CFG_CENTER_Y, pick_value(10));
        write_reg(CFG_LEFT_X, pick_value(10));
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_SCALE_Q, 16'($urandom_range(256, 8192)));
        else
            write_reg(CFG_SCALE_Q, pick_value(16));
        write_reg(CFG_MID_LEVEL, pick_value(8));
        write_reg(CFG_ABSENT_CODE, pick_value(8));
        write_reg(CFG_DRAW_LINES, 16'($urandom_range(0, 1)));
        write_reg(CFG_PEAK_DETECT, 16'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, 16'($urandom));
    endtask

    // Traces of random length: mostly short, some running past the trace width
    task automatic add_traces(input int target);
        int         made;
        int         len;
        logic [7:0] prev_a;
        logic [7:0] a;
        logic [7:0] b;
        made = 0;
        prev_a = 8'($urandom);
        while (made < target)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(270, 300) : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       a = cfg_absent;
                    1:       a = prev_a;
                    2:       a = cfg_mid;
                    default: a = 8'($urandom);
                endcase
                b = ($urandom_range(0, 7) == 0) ? a : 8'($urandom);
                // Drop the start mark now and then: trace continues
                add_word(a, b, k == 0 && $urandom_range(0, 9) != 0);
                prev_a = a;
            end
            made += len;
        end
    endtask

    initial
    begin
        cfg_center = 10'd120;
        cfg_left   = 10'd20;
        cfg_scale  = 16'd4096;
        cfg_mid    = 8'd128;
        cfg_absent = 8'd0;
        cfg_lines  = 1'b1;
        cfg_peak   = 1'b0;
        last_sample  = '0;
        have_history = 1'b0;
        trace_pos    = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        feed_odds  = 4;
        drain_odds = 4;

        // Lines mode at reset values: equal rows, absent current and previous, restart
        add_word(8'd128, 8'hFF, 1'b1);
        add_word(8'd128, 8'h00, 1'b0);
        add_word(8'd255, 8'hFF, 1'b0);
        add_word(8'd0,   8'h00, 1'b0);
        add_word(8'd10,  8'hAA, 1'b0);
        add_word(8'd11,  8'h55, 1'b0);
        add_word(8'd255, 8'hFF, 1'b0);
        add_word(8'd1,   8'h00, 1'b1);
        settle_block();

        // Peak points at the far extremes
        write_reg(CFG_CENTER_Y, 16'd1023);
        write_reg(CFG_MID_LEVEL, 16'd0);
        write_reg(CFG_SCALE_Q, 16'hFFFF);
        write_reg(CFG_LEFT_X, 16'd0);
        write_reg(CFG_DRAW_LINES, 16'd0);
        write_reg(CFG_PEAK_DETECT, 16'd1);
        add_word(8'd0,   8'd255, 1'b1);
        add_word(8'd255, 8'd0,   1'b0);
        add_word(8'd170, 8'd85,  1'b0);
        settle_block();

        // Peak lines: zero scale, then zero-length segments
        write_reg(CFG_DRAW_LINES, 16'd1);
        write_reg(CFG_CENTER_Y, 16'd0);
        write_reg(CFG_MID_LEVEL, 16'd255);
        write_reg(CFG_SCALE_Q, 16'd0);
        add_word(8'd0,   8'd255, 1'b1);
        add_word(8'd255, 8'd0,   1'b0);
        add_word(8'd5,   8'd5,   1'b0);
        settle_block();
        write_reg(CFG_SCALE_Q, 16'd1);
        add_word(8'd0,  8'd255, 1'b0);
        add_word(8'd77, 8'd77,  1'b0);
        settle_block();

        // Plain points: absent code, rows wrapped to a byte, far right column
        write_reg(CFG_DRAW_LINES, 16'd0);
        write_reg(CFG_PEAK_DETECT, 16'd0);
        write_reg(CFG_ABSENT_CODE, 16'd255);
        write_reg(CFG_LEFT_X, 16'd1023);
        write_reg(CFG_CENTER_Y, 16'd1023);
        write_reg(CFG_MID_LEVEL, 16'd0);
        write_reg(CFG_SCALE_Q, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hA5A5);
        add_word(8'd255, 8'd0,   1'b1);
        add_word(8'd0,   8'd255, 1'b0);
        add_word(8'd254, 8'd0,   1'b0);
        add_word(8'd85,  8'd170, 1'b0);
        settle_block();

        // Random settings and traces
        for (int p = 0; p < RANDOM_SETUPS; p++)
        begin
            apply_random_setup();
            feed_odds  = pick_odds();
            drain_odds = pick_odds();
            add_traces(WORDS_PER_SETUP);
            settle_block();
        end

        // Closing stretch without idling: one trace long enough to saturate the index
        feed_odds  = 0;
        drain_odds = 0;
        apply_random_setup();
        for (int k = 0; k < SATURATE_WORDS; k++)
            add_word(8'($urandom), 8'($urandom), k == 0);
        settle_block();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/str_pkg.sv
rtl/core/str_lane.sv
rtl/core/str_merge.sv
rtl/core/str_fifo.sv
rtl/core/scope_trace_rasterizer.sv
test/tb_top.sv
